// ===== rtl/core/acc_spacing_accel_law_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the spacing law unit
// Concurrent check wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ACC_SPACING_ACCEL_LAW_UNIT_MACROS_SVH
`define ACC_SPACING_ACCEL_LAW_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ACCSL_ASSERT_IMPLY(LBL, CLK, RSTN, ANTE, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error("spacing law unit: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ACCSL_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error("spacing law unit: next-cycle check failed");

`else

`define ACCSL_ASSERT_IMPLY(LBL, CLK, RSTN, ANTE, CONS)
`define ACCSL_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS)

`endif

`endif

// ===== rtl/core/accsl_pkg.sv =====
// ----------------------------------------------------------------------------
// accsl_pkg
// Shared widths, register codes, reset values and types of the spacing law.
// ----------------------------------------------------------------------------
package accsl_pkg;

    // Default position width.
    localparam int POS_WIDTH_DEF = 24;

    // Fixed field widths.
    localparam int LEN_W       = 12;
    localparam int SPEED_W     = 15;
    localparam int GAP_W       = 16;
    localparam int DSPEED_W    = 14;
    localparam int GAIN_W      = 16;
    localparam int LIMIT_W     = 16;
    localparam int CMD_W       = 17;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_DESIRED_GAP   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_DESIRED_SPEED = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_GAIN      = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_GAIN    = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_LIMIT   = CFG_INDEX_W'(4);
    localparam logic [CFG_INDEX_W-1:0] REG_DECEL_LIMIT   = CFG_INDEX_W'(5);

    // Register reset values.
    localparam logic [GAP_W-1:0]    DESIRED_GAP_RST   = GAP_W'(1000);
    localparam logic [DSPEED_W-1:0] DESIRED_SPEED_RST = DSPEED_W'(2500);
    localparam logic [GAIN_W-1:0]   GAP_GAIN_RST      = GAIN_W'(128);
    localparam logic [GAIN_W-1:0]   SPEED_GAIN_RST    = GAIN_W'(256);
    localparam logic [LIMIT_W-1:0]  ACCEL_LIMIT_RST   = LIMIT_W'(300);
    localparam logic [LIMIT_W-1:0]  DECEL_LIMIT_RST   = LIMIT_W'(600);

    // Per-item data that rides alongside the distance computation.
    typedef struct packed {
        logic [LEN_W:0]       len_sum;
        logic [SPEED_W-1:0]   speed;
    } accsl_side_t;

    // Control law settings.
    typedef struct packed {
        logic [GAP_W-1:0]    desired_gap;
        logic [DSPEED_W-1:0] desired_speed;
        logic [GAIN_W-1:0]   gap_gain;
        logic [GAIN_W-1:0]   speed_gain;
        logic [LIMIT_W-1:0]  accel_limit;
        logic [LIMIT_W-1:0]  decel_limit;
    } accsl_cfg_t;

endpackage

// ===== rtl/core/accsl_sq.sv =====
// ----------------------------------------------------------------------------
// accsl_sq
// Four-stage pipeline forming the squared centre distance of two vehicles.
// ----------------------------------------------------------------------------
module accsl_sq #(
    parameter int POS_WIDTH = accsl_pkg::POS_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [POS_WIDTH-1:0]       ego_x_pos,
    input  logic signed [POS_WIDTH-1:0]       ego_y_pos,
    input  logic signed [POS_WIDTH-1:0]       lead_x_pos,
    input  logic signed [POS_WIDTH-1:0]       lead_y_pos,
    input  logic [accsl_pkg::LEN_W-1:0]       ego_len,
    input  logic [accsl_pkg::LEN_W-1:0]       lead_len,
    input  logic signed [accsl_pkg::SPEED_W-1:0] ego_speed,
    output logic                              sq_valid,
    output logic [2*POS_WIDTH+1:0]            dist_sq,
    output accsl_pkg::accsl_side_t            sq_side
);
    import accsl_pkg::*;

    localparam int DIFF_W = POS_WIDTH + 1;
    localparam int SQ_W   = 2 * POS_WIDTH + 2;

    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic signed [DIFF_W-1:0] dx_next;
    logic signed [DIFF_W-1:0] dy_next;
    logic [DIFF_W-1:0]        adx_reg;
    logic [DIFF_W-1:0]        ady_reg;
    logic [DIFF_W-1:0]        adx_next;
    logic [DIFF_W-1:0]        ady_next;
    logic [SQ_W-1:0]          sqx_reg;
    logic [SQ_W-1:0]          sqy_reg;
    logic [SQ_W-1:0]          sqx_next;
    logic [SQ_W-1:0]          sqy_next;
    logic [SQ_W-1:0]          sum_reg;
    logic [SQ_W-1:0]          sum_next;
    accsl_side_t              side1_reg;
    accsl_side_t              side2_reg;
    accsl_side_t              side3_reg;
    accsl_side_t              side4_reg;
    accsl_side_t              side1_next;
    logic [3:0]               valid_reg;

    // Stage one: coordinate differences and the combined length.
    always_comb
    begin
        dx_next            = DIFF_W'(lead_x_pos) - DIFF_W'(ego_x_pos);
        dy_next            = DIFF_W'(lead_y_pos) - DIFF_W'(ego_y_pos);
        side1_next.len_sum = (LEN_W + 1)'(ego_len) + (LEN_W + 1)'(lead_len);
        side1_next.speed   = ego_speed;
    end

    // Stage two: magnitudes. The most negative difference maps to 2**POS_WIDTH.
    always_comb
    begin
        adx_next = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
        ady_next = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);
    end

    // Stage three: one multiplier per axis. Stage four: the sum.
    assign sqx_next = adx_reg * adx_reg;
    assign sqy_next = ady_reg * ady_reg;
    assign sum_next = sqx_reg + sqy_reg;

    // Data registers move whenever the pipeline advances.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            side1_reg <= side1_next;
            adx_reg   <= adx_next;
            ady_reg   <= ady_next;
            side2_reg <= side1_reg;
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            side3_reg <= side2_reg;
            sum_reg   <= sum_next;
            side4_reg <= side3_reg;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    assign sq_valid = valid_reg[3];
    assign dist_sq  = sum_reg;
    assign sq_side  = side4_reg;

endmodule

// ===== rtl/core/accsl_sqrt.sv =====
`include "acc_spacing_accel_law_unit_macros.svh"
// ----------------------------------------------------------------------------
// accsl_sqrt
// Pipelined floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module accsl_sqrt #(
    parameter int POS_WIDTH = accsl_pkg::POS_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   rad_valid,
    input  logic [2*POS_WIDTH+1:0] radicand,
    input  accsl_pkg::accsl_side_t rad_side,
    output logic                   root_valid,
    output logic [POS_WIDTH:0]     root,
    output accsl_pkg::accsl_side_t root_side
);
    import accsl_pkg::*;

    localparam int RAD_W  = 2 * POS_WIDTH + 2;
    localparam int ROOT_W = POS_WIDTH + 1;
    localparam int REM_W  = POS_WIDTH + 3;
    localparam int STAGES = ROOT_W;

    logic [REM_W-1:0]  rem_reg  [STAGES];
    logic [ROOT_W-1:0] root_reg [STAGES];
    logic [RAD_W-1:0]  rad_reg  [STAGES];
    accsl_side_t       side_reg [STAGES];
    logic [STAGES-1:0] valid_reg;

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        logic [REM_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [RAD_W-1:0]  rad_prev;
        accsl_side_t       side_prev;
        logic              valid_prev;
        logic [REM_W-1:0]  rem_shift;
        logic [REM_W-1:0]  trial;
        logic              take;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic [RAD_W-1:0]  rad_next;

        // The first stage starts from a zero remainder and root.
        if (k == 0)
        begin : g_first
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign rad_prev   = radicand;
            assign side_prev  = rad_side;
            assign valid_prev = rad_valid;
        end
        else
        begin : g_rest
            assign rem_prev   = rem_reg[k-1];
            assign root_prev  = root_reg[k-1];
            assign rad_prev   = rad_reg[k-1];
            assign side_prev  = side_reg[k-1];
            assign valid_prev = valid_reg[k-1];
        end

        // Bring down two radicand bits and try root*4+1 against the remainder.
        always_comb
        begin
            rem_shift = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
            trial     = {root_prev, 2'b01};
            take      = (rem_shift >= trial);
            rem_next  = take ? (rem_shift - trial) : rem_shift;
            root_next = {root_prev[ROOT_W-2:0], take};
            rad_next  = rad_prev << 2;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_next;
                side_reg[k] <= side_prev;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_prev;
            end
        end
    end

    assign root_valid = valid_reg[STAGES-1];
    assign root       = root_reg[STAGES-1];
    assign root_side  = side_reg[STAGES-1];

    // A floor root leaves a remainder of at most twice the root.
    `ACCSL_ASSERT_IMPLY(a_rem_bound, clk, rst_n, valid_reg[STAGES-1], rem_reg[STAGES-1] <= (REM_W'(root_reg[STAGES-1]) << 1))
    // A held pipeline keeps its last valid bit.
    `ACCSL_ASSERT_NEXT(a_hold_valid, clk, rst_n, !en, $stable(valid_reg[STAGES-1]))
    // An advancing pipeline shifts valid bits by exactly one stage.
    `ACCSL_ASSERT_NEXT(a_shift_valid, clk, rst_n, en, valid_reg[STAGES-1] == $past(valid_reg[STAGES-2]))

endmodule

// ===== rtl/core/accsl_law.sv =====
`include "acc_spacing_accel_law_unit_macros.svh"
// ----------------------------------------------------------------------------
// accsl_law
// Error terms, gain products, scaling and clamp, ending in the output register.
// ----------------------------------------------------------------------------
module accsl_law #(
    parameter int POS_WIDTH = accsl_pkg::POS_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                dist_valid,
    input  logic [POS_WIDTH:0]                  ctr_dist,
    input  accsl_pkg::accsl_side_t              dist_side,
    input  accsl_pkg::accsl_cfg_t               cfg,
    output logic                                out_valid,
    output logic signed [accsl_pkg::CMD_W-1:0]  accel_cmd,
    output logic                                limited
);
    import accsl_pkg::*;

    localparam int GAP_ERR_W = POS_WIDTH + 3;
    localparam int SPD_ERR_W = SPEED_W + 2;
    localparam int GP_W      = GAP_ERR_W + GAIN_W + 1;
    localparam int SP_W      = SPD_ERR_W + GAIN_W + 1;
    localparam int SUM_W     = ((GP_W > SP_W) ? GP_W : SP_W) + 1;
    localparam int ACC_W     = SUM_W - 8;

    logic signed [GAP_ERR_W-1:0] gap_err_reg;
    logic signed [GAP_ERR_W-1:0] gap_err_next;
    logic signed [SPD_ERR_W-1:0] spd_err_reg;
    logic signed [SPD_ERR_W-1:0] spd_err_next;
    logic signed [GAIN_W:0]      gap_gain_s;
    logic signed [GAIN_W:0]      speed_gain_s;
    logic signed [GP_W-1:0]      gp_reg;
    logic signed [GP_W-1:0]      gp_next;
    logic signed [SP_W-1:0]      sp_reg;
    logic signed [SP_W-1:0]      sp_next;
    logic signed [SUM_W-1:0]     sum;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ACC_W-1:0]     acc_next;
    logic signed [ACC_W-1:0]     hi;
    logic signed [ACC_W-1:0]     lo;
    logic signed [ACC_W-1:0]     cmd_full;
    logic                        limited_next;
    logic signed [CMD_W-1:0]     accel_cmd_reg;
    logic                        limited_reg;
    logic [2:0]                  valid_reg;
    logic                        out_valid_reg;

    // Stage one: gap error and speed error.
    always_comb
    begin
        gap_err_next = signed'(GAP_ERR_W'(ctr_dist))
                     - signed'(GAP_ERR_W'(dist_side.len_sum))
                     - signed'(GAP_ERR_W'(cfg.desired_gap));
        spd_err_next = signed'(SPD_ERR_W'(cfg.desired_speed))
                     - SPD_ERR_W'($signed(dist_side.speed));
    end

    // Stage two: gain products, gains taken as positive Q8.8.
    assign gap_gain_s   = signed'({1'b0, cfg.gap_gain});
    assign speed_gain_s = signed'({1'b0, cfg.speed_gain});
    assign gp_next      = gap_err_reg * gap_gain_s;
    assign sp_next      = spd_err_reg * speed_gain_s;

    // Stage three: sum and arithmetic shift, which rounds toward minus infinity.
    assign sum      = SUM_W'(gp_reg) + SUM_W'(sp_reg);
    assign acc_next = ACC_W'(sum >>> 8);

    // Stage four: clamp against the braking and acceleration limits.
    always_comb
    begin
        hi       = signed'(ACC_W'(cfg.accel_limit));
        lo       = -signed'(ACC_W'(cfg.decel_limit));
        cmd_full = acc_reg;
        if (cmd_full > hi)
        begin
            cmd_full = hi;
        end
        if (cmd_full < lo)
        begin
            cmd_full = lo;
        end
        limited_next = (cmd_full != acc_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gap_err_reg   <= gap_err_next;
            spd_err_reg   <= spd_err_next;
            gp_reg        <= gp_next;
            sp_reg        <= sp_next;
            acc_reg       <= acc_next;
            accel_cmd_reg <= cmd_full[CMD_W-1:0];
            limited_reg   <= limited_next;
        end
    end

    // Valid bits, the last one being the output register's.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg     <= {valid_reg[1:0], dist_valid};
            out_valid_reg <= valid_reg[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign accel_cmd = accel_cmd_reg;
    assign limited   = limited_reg;

    // A clamped value sits on one of the two limits.
    `ACCSL_ASSERT_IMPLY(a_clamp_edge, clk, rst_n, valid_reg[2] && limited_next, (cmd_full == hi) || (cmd_full == lo))
    // The command never leaves the limit window.
    `ACCSL_ASSERT_IMPLY(a_clamp_window, clk, rst_n, valid_reg[2], (cmd_full <= hi) && (cmd_full >= lo))
    // The output register takes the clamped value when the pipeline advances.
    `ACCSL_ASSERT_NEXT(a_out_load, clk, rst_n, en && valid_reg[2], out_valid_reg && (accel_cmd_reg == $past(cmd_full[CMD_W-1:0])))

endmodule

// ===== rtl/core/acc_spacing_accel_law_unit.sv =====
// ----------------------------------------------------------------------------
// acc_spacing_accel_law_unit
// Adaptive cruise spacing law: distance, error terms and clamped command.
// ----------------------------------------------------------------------------
// One acceleration command comes out for every item taken in, in order. The
// unit accepts an item in every cycle in which in_stall is low. Four stages
// form the squared distance, the square root resolves one bit per stage over
// POS_WIDTH + 1 stages, and four more form the errors, products, shift and
// clamp. The whole pipeline holds only while its output register is full and
// stalled, so in_stall is high exactly then. Configuration writes are always
// ready and must be made while no item is in flight.
module acc_spacing_accel_law_unit #(
    parameter int POS_WIDTH = accsl_pkg::POS_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Input item channel.
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [POS_WIDTH-1:0]             ego_x_pos,
    input  logic signed [POS_WIDTH-1:0]             ego_y_pos,
    input  logic signed [POS_WIDTH-1:0]             lead_x_pos,
    input  logic signed [POS_WIDTH-1:0]             lead_y_pos,
    input  logic [accsl_pkg::LEN_W-1:0]             ego_len,
    input  logic [accsl_pkg::LEN_W-1:0]             lead_len,
    input  logic signed [accsl_pkg::SPEED_W-1:0]    ego_speed,
    // Result item channel.
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [accsl_pkg::CMD_W-1:0]      accel_cmd,
    output logic                                    limited,
    // Configuration write channel.
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [accsl_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [accsl_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import accsl_pkg::*;

    logic                   adv;
    logic                   sq_valid;
    logic [2*POS_WIDTH+1:0] dist_sq;
    accsl_side_t            sq_side;
    logic                   root_valid;
    logic [POS_WIDTH:0]     root;
    accsl_side_t            root_side;
    accsl_cfg_t             cfg;

    logic [GAP_W-1:0]       desired_gap_reg;
    logic [DSPEED_W-1:0]    desired_speed_reg;
    logic [GAIN_W-1:0]      gap_gain_reg;
    logic [GAIN_W-1:0]      speed_gain_reg;
    logic [LIMIT_W-1:0]     accel_limit_reg;
    logic [LIMIT_W-1:0]     decel_limit_reg;

    // The pipeline advances unless a finished result is stalled at the output.
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // Configuration registers; unknown indexes are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desired_gap_reg   <= DESIRED_GAP_RST;
            desired_speed_reg <= DESIRED_SPEED_RST;
            gap_gain_reg      <= GAP_GAIN_RST;
            speed_gain_reg    <= SPEED_GAIN_RST;
            accel_limit_reg   <= ACCEL_LIMIT_RST;
            decel_limit_reg   <= DECEL_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DESIRED_GAP:   desired_gap_reg   <= cfg_data[GAP_W-1:0];
                REG_DESIRED_SPEED: desired_speed_reg <= cfg_data[DSPEED_W-1:0];
                REG_GAP_GAIN:      gap_gain_reg      <= cfg_data[GAIN_W-1:0];
                REG_SPEED_GAIN:    speed_gain_reg    <= cfg_data[GAIN_W-1:0];
                REG_ACCEL_LIMIT:   accel_limit_reg   <= cfg_data[LIMIT_W-1:0];
                REG_DECEL_LIMIT:   decel_limit_reg   <= cfg_data[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.desired_gap   = desired_gap_reg;
        cfg.desired_speed = desired_speed_reg;
        cfg.gap_gain      = gap_gain_reg;
        cfg.speed_gain    = speed_gain_reg;
        cfg.accel_limit   = accel_limit_reg;
        cfg.decel_limit   = decel_limit_reg;
    end

    // Squared centre distance.
    accsl_sq #(
        .POS_WIDTH (POS_WIDTH)
    ) u_sq (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (in_valid),
        .ego_x_pos  (ego_x_pos),
        .ego_y_pos  (ego_y_pos),
        .lead_x_pos (lead_x_pos),
        .lead_y_pos (lead_y_pos),
        .ego_len    (ego_len),
        .lead_len   (lead_len),
        .ego_speed  (ego_speed),
        .sq_valid   (sq_valid),
        .dist_sq    (dist_sq),
        .sq_side    (sq_side)
    );

    // Floor square root.
    accsl_sqrt #(
        .POS_WIDTH (POS_WIDTH)
    ) u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .rad_valid  (sq_valid),
        .radicand   (dist_sq),
        .rad_side   (sq_side),
        .root_valid (root_valid),
        .root       (root),
        .root_side  (root_side)
    );

    // Control law and output register.
    accsl_law #(
        .POS_WIDTH (POS_WIDTH)
    ) u_law (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .dist_valid (root_valid),
        .ctr_dist   (root),
        .dist_side  (root_side),
        .cfg        (cfg),
        .out_valid  (out_valid),
        .accel_cmd  (accel_cmd),
        .limited    (limited)
    );

endmodule
